### rtl/core/ilsa_pkg.sv
// Shared constants, command and status codes, and the cell control word
// for the indexed list shift array. No dependencies.
`default_nettype none

package ilsa_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int WIDE_W = 64;

  // Position and count compares run at this width; covers DEPTH up to 1024
  localparam int CTRL_W = 11;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef logic [1:0] cell_mode_t;

  localparam cell_mode_t MODE_HOLD = 2'd0;
  localparam cell_mode_t MODE_INS  = 2'd1;
  localparam cell_mode_t MODE_DEL  = 2'd2;
  localparam cell_mode_t MODE_REV  = 2'd3;

  // Broadcast to every cell; pos doubles as the step index during reverse
  typedef struct packed {
    cell_mode_t          mode;
    logic [CTRL_W-1:0]   pos;
    logic [CTRL_W-1:0]   cnt;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/ilsa_cell.sv
// One list slot: holds a word, takes it from a neighbor, the write bus or
// keeps it, and flags a match against the search key. Uses ilsa_pkg.
`default_nettype none

module ilsa_cell #(
  parameter int INDEX      = 0,
  parameter int WORD_WIDTH = ilsa_pkg::WORD_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire ilsa_pkg::cell_ctrl_t ctrl,
  input  wire  [WORD_WIDTH-1:0]    key,
  input  wire  [WORD_WIDTH-1:0]    wr_word,
  input  wire  [WORD_WIDTH-1:0]    lower_q,
  input  wire  [WORD_WIDTH-1:0]    upper_q,
  output logic [WORD_WIDTH-1:0]    q,
  output logic                     match
);

  import ilsa_pkg::*;

  localparam logic [CTRL_W-1:0] IDX = CTRL_W'(INDEX);

  logic [WORD_WIDTH-1:0] q_r;
  logic [WORD_WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctrl.mode)
      MODE_INS: begin
        if (IDX == ctrl.pos) begin
          q_nxt = wr_word;
        end else if (IDX > ctrl.pos && IDX <= ctrl.cnt) begin
          q_nxt = lower_q;
        end
      end
      MODE_DEL: begin
        if (IDX >= ctrl.pos && (IDX + CTRL_W'(1)) < ctrl.cnt) begin
          q_nxt = upper_q;
        end
      end
      MODE_REV: begin
        // take the tail word at the step slot, push the rest of the span up
        if (IDX == ctrl.pos) begin
          q_nxt = wr_word;
        end else if (IDX > ctrl.pos && IDX < ctrl.cnt) begin
          q_nxt = lower_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q     = q_r;
  assign match = (q_r == key) && (IDX < ctrl.cnt);

endmodule

`default_nettype wire

### rtl/core/indexed_list_shift_array_core.sv
// Insert, delete, get and unused codes go from accept through the execute state to
// out_valid; search adds a match-read state, and reverse of more than one entry adds
// one cell shift per step. busy stays high until the result is registered; a new
// start is taken in the cycle the result is shown.
// Reset (synchronous, rst_n low) empties the list; slot contents are not cleared.
// Results are a one-cycle strobe on out_valid; the receiver cannot stall.
`default_nettype none

module indexed_list_shift_array_core #(
  parameter int DEPTH      = ilsa_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = ilsa_pkg::WORD_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [ilsa_pkg::CMD_W-1:0]        in_cmd,
  input  wire  [ilsa_pkg::POS_W-1:0]        in_position,
  input  wire  signed [ilsa_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [ilsa_pkg::VAL_W-1:0] out_read_value,
  output logic signed [ilsa_pkg::POS_W-1:0] out_found_position,
  output logic [ilsa_pkg::POS_W-1:0]        out_entry_count,
  output logic [ilsa_pkg::STAT_W-1:0]       out_status
);

  import ilsa_pkg::*;

  localparam int IDXW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_REV  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic [IDXW-1:0]       k_r, k_nxt;
  logic [DEPTH-1:0]      match_r;

  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_rd_r;
  logic [POS_W-1:0]      out_found_r;
  logic [POS_W-1:0]      out_count_r;
  logic [STAT_W-1:0]     out_status_r;

  logic                  emit;
  logic [VAL_W-1:0]      rd_nxt;
  logic [POS_W-1:0]      found_nxt;
  logic [STAT_W-1:0]     status_nxt;

  logic                  accept;
  logic [WIDE_W-1:0]     value_wide;
  logic [CTRL_W-1:0]     pos_ext;
  logic [CTRL_W-1:0]     count_ext;
  logic [CTRL_W-1:0]     count_nxt_ext;
  logic [CTRL_W-1:0]     tail_full;
  logic [IDXW-1:0]       tail_idx;
  logic [IDXW-1:0]       get_idx;
  logic signed [WORD_WIDTH-1:0] get_word;
  logic [WIDE_W-1:0]     get_wide;
  logic [IDXW-1:0]       found_idx;
  logic                  found_any;
  logic [CTRL_W-1:0]     found_ext;

  cell_ctrl_t            ctrl;
  logic [WORD_WIDTH-1:0] wr_word;
  logic [WORD_WIDTH-1:0] cell_q  [DEPTH];
  logic [WORD_WIDTH-1:0] lower_w [DEPTH];
  logic [WORD_WIDTH-1:0] upper_w [DEPTH];
  logic [DEPTH-1:0]      match_w;

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign value_wide = WIDE_W'(in_value);

  assign pos_ext   = CTRL_W'(pos_r);
  assign count_ext = CTRL_W'(count_r);
  assign tail_full = count_ext - CTRL_W'(1);
  assign tail_idx  = tail_full[IDXW-1:0];
  assign get_idx   = pos_ext[IDXW-1:0];
  assign get_word  = cell_q[get_idx];
  assign get_wide  = WIDE_W'(get_word);
  assign wr_word   = (state_r == S_REV) ? cell_q[tail_idx] : word_r;

  // Row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lower_w[g] = word_r;
    end else begin : g_lower
      assign lower_w[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper_w[g] = cell_q[g];
    end else begin : g_upper
      assign upper_w[g] = cell_q[g+1];
    end

    ilsa_cell #(
      .INDEX      (g),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .key     (word_r),
      .wr_word (wr_word),
      .lower_q (lower_w[g]),
      .upper_q (upper_w[g]),
      .q       (cell_q[g]),
      .match   (match_w[g])
    );
  end

  // Lowest matching slot from the registered match vector
  always_comb begin
    found_idx = '0;
    found_any = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        found_idx = IDXW'(i);
        found_any = 1'b1;
      end
    end
  end
  assign found_ext = CTRL_W'(found_idx);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    emit       = 1'b0;
    rd_nxt     = '0;
    found_nxt  = '0;
    status_nxt = ST_OK;
    ctrl.mode  = MODE_HOLD;
    ctrl.pos   = pos_ext;
    ctrl.cnt   = count_ext;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        emit      = 1'b1;
        case (cmd_r)
          CMD_INSERT: begin
            if (pos_ext > count_ext) begin
              status_nxt = ST_RANGE;
            end else if (count_ext == CTRL_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ctrl.mode = MODE_INS;
              count_nxt = CNTW'(count_r + 1'b1);
            end
          end
          CMD_DELETE: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              ctrl.mode = MODE_DEL;
              count_nxt = CNTW'(count_r - 1'b1);
            end
          end
          CMD_GET: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              rd_nxt = get_wide[VAL_W-1:0];
            end
          end
          CMD_SEARCH: begin
            emit      = 1'b0;
            state_nxt = S_SRCH;
          end
          CMD_REVERSE: begin
            if (count_ext > CTRL_W'(1)) begin
              emit      = 1'b0;
              state_nxt = S_REV;
              k_nxt     = '0;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_SRCH: begin
        emit      = 1'b1;
        state_nxt = S_IDLE;
        found_nxt = found_any ? found_ext[POS_W-1:0] : '1;
      end
      S_REV: begin
        ctrl.mode = MODE_REV;
        ctrl.pos  = CTRL_W'(k_r);
        k_nxt     = IDXW'(k_r + 1'b1);
        // last step moves the old first word into place
        if ((CTRL_W'(k_r) + CTRL_W'(2)) == count_ext) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign count_nxt_ext = CTRL_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= emit;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    match_r <= match_w;
    k_r     <= k_nxt;
    if (accept) begin
      cmd_r  <= in_cmd;
      pos_r  <= in_position;
      word_r <= value_wide[WORD_WIDTH-1:0];
    end
    if (emit) begin
      out_rd_r     <= rd_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= count_nxt_ext[POS_W-1:0];
      out_status_r <= status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_found_r;
  assign out_entry_count    = out_count_r;
  assign out_status         = out_status_r;

endmodule

`default_nettype wire

### rtl/core/ilsa_checker.sv
// Port-level checks on the indexed list shift array core, bound to the top.
// Depends on ilsa_pkg and indexed_list_shift_array_core.
`default_nettype none

module ilsa_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               start,
  input wire                               busy,
  input wire                               out_valid,
  input wire signed [ilsa_pkg::VAL_W-1:0]  out_read_value,
  input wire signed [ilsa_pkg::POS_W-1:0]  out_found_position,
  input wire [ilsa_pkg::STAT_W-1:0]        out_status
);

  import ilsa_pkg::*;

  // an accepted word always occupies the block for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // a result is shown only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // results never run back to back
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in consecutive cycles");

  // a failed command reads nothing and finds nothing
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_read_value == '0 && out_found_position == '0))
    else $error("failed command carries data");

endmodule

bind indexed_list_shift_array_core ilsa_checker u_ilsa_checker (.*);

`default_nettype wire
